@@ rtl/ufilt_pkg.sv @@
// Shared types and constants of the UTF-8 validating character filter.
// Used by the top level, the front end and the engine; depends on nothing else.
package ufilt_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_BYTE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHABET_SIZE    = 2'd2;

    // Filter modes; any other code behaves as keep mode.
    localparam logic [1:0] MODE_REPLACE = 2'd0;
    localparam logic [1:0] MODE_REMOVE  = 2'd1;
    localparam logic [1:0] MODE_KEEP    = 2'd2;

    localparam logic [7:0] REPLACEMENT_RESET = 8'h20;

    // Command passed from the front end to the engine.
    typedef struct packed {
        logic        is_entry;
        logic        entry_ok;
        logic        has_byte;
        logic        is_final;
        logic [7:0]  text_byte;
        logic [3:0]  entry_index;
        logic [31:0] entry_bytes;
        logic [2:0]  entry_length;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       text_end;
    } result_t;

    // One alphabet table word.
    typedef struct packed {
        logic [2:0]  len;
        logic [31:0] chars;
    } alpha_entry_t;

    // Configuration seen by the engine.
    typedef struct packed {
        logic [1:0] filter_mode;
        logic [7:0] replacement_byte;
        logic [4:0] alphabet_size;
    } cfg_t;

endpackage

@@ rtl/utf8_validating_char_filter_top.sv @@
// Top level of the UTF-8 validating character filter: configuration registers,
// front end, command queue, engine and result queue. Depends on ufilt_pkg.
//
// Channel  | Handshake                          | Payload
// input    | push / full (accept: push&!full)   | kind, text_byte, text_last,
//          |                                    |   entry_index, entry_bytes, entry_length
// result   | pop / empty (accept: pop&!empty)   | out_byte, byte_valid, run_last, text_end
// config   | cfg_wr_en                          | cfg_index, cfg_data
//
// Each item passes through the front register. In the engine a text byte passes take,
// classify and close steps; each invalid byte adds a classify step, and each complete
// character adds a classify step, alphabet entry reads one at a time through the single
// read port until a hit or the table size, and an act step that emits its bytes, if any.
// The engine does table writes while idle. A full result queue stalls the engine, and the
// command queue lets the input run ahead. Reset clears control state only; no clearing pass.
module utf8_validating_char_filter_top #(
    parameter int ALPHABET_ENTRIES   = 16,
    parameter int CMD_QUEUE_DEPTH    = 2,
    parameter int RESULT_QUEUE_DEPTH = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               kind,
    input  logic [7:0]                         text_byte,
    input  logic                               text_last,
    input  logic [3:0]                         entry_index,
    input  logic [31:0]                        entry_bytes,
    input  logic [2:0]                         entry_length,
    output logic                               empty,
    input  logic                               pop,
    output logic [7:0]                         out_byte,
    output logic                               byte_valid,
    output logic                               run_last,
    output logic                               text_end,
    input  logic                               cfg_wr_en,
    input  logic [ufilt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ufilt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import ufilt_pkg::*;

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(result_t);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic             fe_push;
    cmd_t             fe_cmd;
    logic             cmdq_full;
    logic             cmdq_empty;
    logic [CMD_W-1:0] cmdq_rd_data;
    logic             cmdq_pop;
    logic             res_push;
    result_t          res_data;
    logic             resq_full;
    logic [RES_W-1:0] resq_rd_data;
    result_t          res_head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FILTER_MODE:      cfg_next.filter_mode      = cfg_data[1:0];
                REG_REPLACEMENT_BYTE: cfg_next.replacement_byte = cfg_data[7:0];
                REG_ALPHABET_SIZE:    cfg_next.alphabet_size    = cfg_data[4:0];
                default:              cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{filter_mode: MODE_REPLACE, replacement_byte: REPLACEMENT_RESET,
                         alphabet_size: 5'd0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ufilt_front #(
        .ALPHABET_ENTRIES(ALPHABET_ENTRIES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .text_byte    (text_byte),
        .text_last    (text_last),
        .entry_index  (entry_index),
        .entry_bytes  (entry_bytes),
        .entry_length (entry_length),
        .cmd_push     (fe_push),
        .cmd_data     (fe_cmd),
        .cmd_full     (cmdq_full)
    );

    ufilt_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fe_push),
        .wr_data (fe_cmd),
        .full    (cmdq_full),
        .rd_en   (cmdq_pop),
        .rd_data (cmdq_rd_data),
        .empty   (cmdq_empty)
    );

    ufilt_back #(
        .ALPHABET_ENTRIES(ALPHABET_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd_t'(cmdq_rd_data)),
        .cmd_empty (cmdq_empty),
        .cmd_pop   (cmdq_pop),
        .out_push  (res_push),
        .out_data  (res_data),
        .out_full  (resq_full)
    );

    ufilt_fifo #(
        .WIDTH(RES_W),
        .DEPTH(RESULT_QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .full    (resq_full),
        .rd_en   (pop),
        .rd_data (resq_rd_data),
        .empty   (empty)
    );

    assign res_head   = result_t'(resq_rd_data);
    assign out_byte   = res_head.out_byte;
    assign byte_valid = res_head.byte_valid;
    assign run_last   = res_head.run_last;
    assign text_end   = res_head.text_end;

endmodule

@@ rtl/ufilt_fifo.sv @@
// Small synchronous queue used between the front end, the engine and the result side.
// Depends on no package.
module ufilt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/ufilt_front.sv @@
// Input stage: registers each accepted item and decodes it into an engine command.
// Depends on ufilt_pkg.
module ufilt_front #(
    parameter int ALPHABET_ENTRIES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               kind,
    input  logic [7:0]         text_byte,
    input  logic               text_last,
    input  logic [3:0]         entry_index,
    input  logic [31:0]        entry_bytes,
    input  logic [2:0]         entry_length,
    output logic               cmd_push,
    output ufilt_pkg::cmd_t    cmd_data,
    input  logic               cmd_full
);

    import ufilt_pkg::*;

    logic fv_reg;
    logic fv_next;
    logic accept;
    cmd_t cmd_reg;
    cmd_t cmd_next;

    // The stage can take a new item whenever its current one moves on.
    assign full     = fv_reg && cmd_full;
    assign accept   = push && !full;
    assign cmd_push = fv_reg;
    assign cmd_data = cmd_reg;

    always_comb
    begin
        cmd_next              = cmd_reg;
        fv_next               = fv_reg;
        if (fv_reg && !cmd_full)
        begin
            fv_next = 1'b0;
        end
        if (accept)
        begin
            fv_next               = 1'b1;
            cmd_next.is_entry     = kind;
            cmd_next.entry_ok     = kind && (9'(entry_index) < 9'(ALPHABET_ENTRIES));
            cmd_next.has_byte     = (text_byte != 8'd0);
            cmd_next.is_final     = text_last || (text_byte == 8'd0);
            cmd_next.text_byte    = text_byte;
            cmd_next.entry_index  = entry_index;
            cmd_next.entry_bytes  = entry_bytes;
            cmd_next.entry_length = entry_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

@@ rtl/ufilt_back.sv @@
// Engine: holds pending bytes, splits them into UTF-8 characters, scans the
// alphabet memory and produces result items. Depends on ufilt_pkg.
module ufilt_back #(
    parameter int ALPHABET_ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ufilt_pkg::cfg_t     cfg,
    input  ufilt_pkg::cmd_t     cmd,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    output logic                out_push,
    output ufilt_pkg::result_t  out_data,
    input  logic                out_full
);

    import ufilt_pkg::*;

    localparam int AW   = (ALPHABET_ENTRIES > 1) ? $clog2(ALPHABET_ENTRIES) : 1;
    localparam int SCW  = $clog2(ALPHABET_ENTRIES + 1);
    localparam int CMPW = (SCW > 5) ? SCW : 5;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_MATCH  = 3'd2;
    localparam logic [2:0] ST_ACT    = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    typedef struct packed {
        logic       need_more;
        logic       invalid;
        logic [2:0] len;
    } cls_t;

    function automatic logic in_rng(input logic [7:0] b, input logic [7:0] lo,
                                    input logic [7:0] hi);
        return (b >= lo) && (b <= hi);
    endfunction

    // Looks at the character that starts at the first pending byte.
    function automatic cls_t classify(input logic [3:0][7:0] p, input logic [2:0] n,
                                      input logic fin);
        cls_t       r;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [2:0] len;
        logic       lead_ok;
        r       = '{need_more: 1'b0, invalid: 1'b0, len: 3'd1};
        lo      = 8'h80;
        hi      = 8'hBF;
        len     = 3'd1;
        lead_ok = 1'b1;
        if (p[0] == 8'h09 || p[0] == 8'h0A || p[0] == 8'h0D || in_rng(p[0], 8'h20, 8'h7E))
        begin
            len = 3'd1;
        end
        else if (in_rng(p[0], 8'hC2, 8'hDF))
        begin
            len = 3'd2;
        end
        else if (p[0] == 8'hE0)
        begin
            len = 3'd3;
            lo  = 8'hA0;
        end
        else if (p[0] == 8'hED)
        begin
            len = 3'd3;
            hi  = 8'h9F;
        end
        else if (in_rng(p[0], 8'hE1, 8'hEF))
        begin
            len = 3'd3;
        end
        else if (p[0] == 8'hF0)
        begin
            len = 3'd4;
            lo  = 8'h90;
        end
        else if (in_rng(p[0], 8'hF1, 8'hF3))
        begin
            len = 3'd4;
        end
        else if (p[0] == 8'hF4)
        begin
            len = 3'd4;
            hi  = 8'h8F;
        end
        else
        begin
            lead_ok = 1'b0;
        end
        r.len = len;
        if (!lead_ok)
        begin
            r.invalid = 1'b1;
        end
        else if (len == 3'd1)
        begin
            r.invalid = 1'b0;
        end
        else if (n < 3'd2)
        begin
            r.invalid   = fin;
            r.need_more = !fin;
        end
        else if (!in_rng(p[1], lo, hi))
        begin
            r.invalid = 1'b1;
        end
        else if (len == 3'd2)
        begin
            r.invalid = 1'b0;
        end
        else if (n < 3'd3)
        begin
            r.invalid   = fin;
            r.need_more = !fin;
        end
        else if (!in_rng(p[2], 8'h80, 8'hBF))
        begin
            r.invalid = 1'b1;
        end
        else if (len == 3'd3)
        begin
            r.invalid = 1'b0;
        end
        else if (n < 3'd4)
        begin
            r.invalid   = fin;
            r.need_more = !fin;
        end
        else if (!in_rng(p[3], 8'h80, 8'hBF))
        begin
            r.invalid = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [31:0] len_mask(input logic [2:0] len);
        logic [31:0] m;
        case (len)
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    alpha_entry_t      alpha_mem [ALPHABET_ENTRIES];
    alpha_entry_t      rd_data_reg;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [3:0][7:0]   pend_reg;
    logic [3:0][7:0]   pend_next;
    logic [2:0]        n_reg;
    logic [2:0]        n_next;
    logic              final_reg;
    logic              final_next;
    logic [2:0]        cur_len_reg;
    logic [2:0]        cur_len_next;
    logic              hit_reg;
    logic              hit_next;
    logic [1:0]        emit_idx_reg;
    logic [1:0]        emit_idx_next;
    logic [SCW-1:0]    issue_idx_reg;
    logic [SCW-1:0]    issue_idx_next;
    logic              rd_vld_reg;
    logic [7:0]        held_reg;
    logic [7:0]        held_next;
    logic              held_vld_reg;
    logic              held_vld_next;

    cls_t              cls;
    logic [CMPW-1:0]   size_ext;
    logic [SCW-1:0]    eff_size;
    logic              cmp_hit;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [AW+3:0]     wr_idx_ext;
    logic [AW-1:0]     wr_addr;
    logic              is_replace;
    logic              is_remove;
    logic              can_go;
    logic              want_emit;
    logic [7:0]        emit_val;
    logic              do_shift;
    logic [2:0]        shift_k;

    assign cls        = classify(pend_reg, n_reg, final_reg);
    assign size_ext   = CMPW'(cfg.alphabet_size);
    assign eff_size   = (size_ext > CMPW'(ALPHABET_ENTRIES)) ? SCW'(ALPHABET_ENTRIES)
                                                             : size_ext[SCW-1:0];
    assign cmp_hit    = (rd_data_reg.len == cur_len_reg) &&
                        (((rd_data_reg.chars ^ pend_reg) & len_mask(cur_len_reg)) == 32'd0);
    assign rd_en      = (state_reg == ST_MATCH) && (issue_idx_reg < eff_size);
    assign rd_addr    = issue_idx_reg[AW-1:0];
    assign wr_idx_ext = (AW + 4)'(cmd.entry_index);
    assign wr_addr    = wr_idx_ext[AW-1:0];
    assign is_replace = (cfg.filter_mode == MODE_REPLACE);
    assign is_remove  = (cfg.filter_mode == MODE_REMOVE);
    // A produced byte waits in the held register until the next one shows
    // whether it is the last result of its input item.
    assign can_go     = !(held_vld_reg && out_full);

    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        n_next         = n_reg;
        final_next     = final_reg;
        cur_len_next   = cur_len_reg;
        hit_next       = hit_reg;
        emit_idx_next  = emit_idx_reg;
        issue_idx_next = issue_idx_reg;
        held_next      = held_reg;
        held_vld_next  = held_vld_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        out_push       = 1'b0;
        out_data       = '0;
        want_emit      = 1'b0;
        emit_val       = pend_reg[0];
        do_shift       = 1'b0;
        shift_k        = 3'd1;

        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.is_entry)
                    begin
                        mem_we = cmd.entry_ok;
                    end
                    else
                    begin
                        if (cmd.has_byte)
                        begin
                            pend_next[n_reg[1:0]] = cmd.text_byte;
                            n_next                = n_reg + 3'd1;
                        end
                        final_next = cmd.is_final;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (n_reg == 3'd0 || cls.need_more)
                begin
                    state_next = ST_FINISH;
                end
                else if (cls.invalid)
                begin
                    want_emit = 1'b1;
                    emit_val  = is_replace ? cfg.replacement_byte : pend_reg[0];
                    do_shift  = can_go;
                    shift_k   = 3'd1;
                end
                else
                begin
                    cur_len_next   = cls.len;
                    issue_idx_next = '0;
                    state_next     = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                if (rd_en)
                begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                if (rd_vld_reg && cmp_hit)
                begin
                    hit_next      = 1'b1;
                    emit_idx_next = 2'd0;
                    state_next    = ST_ACT;
                end
                else if (issue_idx_reg >= eff_size)
                begin
                    hit_next      = 1'b0;
                    emit_idx_next = 2'd0;
                    state_next    = ST_ACT;
                end
            end
            ST_ACT:
            begin
                shift_k = cur_len_reg;
                if (is_replace && hit_reg)
                begin
                    want_emit = 1'b1;
                    emit_val  = cfg.replacement_byte;
                    if (can_go)
                    begin
                        do_shift   = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
                else if (is_replace || (is_remove ? !hit_reg : hit_reg))
                begin
                    want_emit = 1'b1;
                    emit_val  = pend_reg[emit_idx_reg];
                    if (can_go)
                    begin
                        if ({1'b0, emit_idx_reg} == cur_len_reg - 3'd1)
                        begin
                            do_shift   = 1'b1;
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            emit_idx_next = emit_idx_reg + 2'd1;
                        end
                    end
                end
                else
                begin
                    do_shift   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_FINISH:
            begin
                if (held_vld_reg)
                begin
                    if (!out_full)
                    begin
                        out_push      = 1'b1;
                        out_data      = '{out_byte: held_reg, byte_valid: 1'b1,
                                          run_last: 1'b1, text_end: final_reg};
                        held_vld_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
                else if (final_reg)
                begin
                    if (!out_full)
                    begin
                        out_push   = 1'b1;
                        out_data   = '{out_byte: 8'd0, byte_valid: 1'b0,
                                       run_last: 1'b1, text_end: 1'b1};
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (want_emit && can_go)
        begin
            if (held_vld_reg)
            begin
                out_push = 1'b1;
                out_data = '{out_byte: held_reg, byte_valid: 1'b1,
                             run_last: 1'b0, text_end: 1'b0};
            end
            held_next     = emit_val;
            held_vld_next = 1'b1;
        end

        if (do_shift)
        begin
            pend_next = pend_reg >> {shift_k, 3'b000};
            n_next    = n_reg - shift_k;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= 3'd0;
            final_reg     <= 1'b0;
            held_vld_reg  <= 1'b0;
            rd_vld_reg    <= 1'b0;
            emit_idx_reg  <= 2'd0;
            issue_idx_reg <= '0;
            hit_reg       <= 1'b0;
            cur_len_reg   <= 3'd1;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            final_reg     <= final_next;
            held_vld_reg  <= held_vld_next;
            rd_vld_reg    <= rd_en;
            emit_idx_reg  <= emit_idx_next;
            issue_idx_reg <= issue_idx_next;
            hit_reg       <= hit_next;
            cur_len_reg   <= cur_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        held_reg <= held_next;
    end

    // Alphabet table: one write port for table commands, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            alpha_mem[wr_addr] <= '{len: cmd.entry_length, chars: cmd.entry_bytes};
        end
        if (rd_en)
        begin
            rd_data_reg <= alpha_mem[rd_addr];
        end
    end

    // Between input items no more than three bytes may remain pending.
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (n_reg <= 3'd3))
        else $error("pending byte count above three between items");

    // The end of a text leaves nothing pending.
    a_final_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && final_reg && state_next == ST_IDLE) |-> (n_reg == 3'd0))
        else $error("pending bytes left at end of text");

    // Read data is only valid right after a scan cycle issued the read.
    a_rd_after_match: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(state_reg == ST_MATCH))
        else $error("alphabet read outside the scan");

    // No held byte survives the close of an input item.
    a_held_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !held_vld_reg)
        else $error("held byte left over at item close");

    // The engine never pushes into a full result queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result pushed into full queue");

endmodule
